// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the random generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property checked at every rising clock edge outside reset.
`define MWC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("mwc assertion failed");

// Condition that must never be true outside reset.
`define MWC_ASSERT_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("mwc forbidden condition seen");

`endif

// ===== rtl/core/mwc_pkg.sv =====
// Shared types and constants of the multiply-with-carry random generator.
package mwc_pkg;

   localparam int unsigned WordWidth = 32;

   localparam logic [31:0] ScaleLimit = 32'h003F_FFFF;
   localparam logic [15:0] MultZ      = 16'd36969;
   localparam logic [15:0] MultW      = 16'd18000;
   localparam logic [31:0] SeedZ      = 32'd2;
   localparam logic [31:0] SeedW      = 32'd1;
   localparam logic [4:0]  MaxShift   = 5'd31;

   typedef enum logic [1:0] {
      CMD_RANGE = 2'd0,
      CMD_BITS  = 2'd1,
      CMD_SEED  = 2'd2
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COUNT_DIV,
      ST_COUNT_WAIT,
      ST_ADVANCE,
      ST_SCALE_MUL,
      ST_SCALE_FIX,
      ST_MOD_DIV,
      ST_MOD_WAIT,
      ST_OFFSET_MUL,
      ST_FINISH
   } state_type;

   typedef enum logic {
      DIV_COUNT,
      DIV_MOD
   } div_sel_type;

   typedef enum logic {
      MUL_SCALE,
      MUL_OFFSET
   } mul_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load_req;
      logic        seed_en;
      logic        div_start;
      div_sel_type div_sel;
      logic        count_load;
      logic        advance;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        scale_fix;
      logic        mod_load;
      logic        out_load;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_busy;
      logic div_done;
      logic big_n;
      logic out_free;
   } dp_status_type;

endpackage

// ===== rtl/core/mwc_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module mwc_div import mwc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WordWidth-1:0] dividend,
   input  logic [WordWidth-1:0] divisor,
   output logic                 busy,
   output logic                 done,
   output logic [WordWidth-1:0] quotient,
   output logic [WordWidth-1:0] remainder
);

   localparam int unsigned CntWidth = $clog2(WordWidth);

   logic [WordWidth-1:0] rem_ff, rem_in;
   logic [WordWidth-1:0] quo_ff, quo_in;
   logic [WordWidth-1:0] dvs_ff, dvs_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [WordWidth:0]   shifted;
   logic [WordWidth+1:0] trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[WordWidth-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CntWidth'(WordWidth - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Keep the trial difference when it did not go negative.
         if (trial[WordWidth+1]) begin
            rem_in = shifted[WordWidth-1:0];
            quo_in = {quo_ff[WordWidth-2:0], 1'b0};
         end else begin
            rem_in = trial[WordWidth-1:0];
            quo_in = {quo_ff[WordWidth-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/core/mwc_datapath.sv =====
// Generator state, operand registers, shared multiplier and divider.
`include "assert_macros.svh"
module mwc_datapath import mwc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   output dp_status_type        status,
   input  logic [1:0]           req_cmd,
   input  logic [WordWidth-1:0] req_range_start,
   input  logic [WordWidth-1:0] req_range_stop,
   input  logic [WordWidth-1:0] req_range_step,
   input  logic [7:0]           req_bit_count,
   input  logic [WordWidth-1:0] req_seed_first,
   input  logic [WordWidth-1:0] req_seed_second,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WordWidth-1:0] rsp_random_value
);

   logic [WordWidth-1:0]   z_ff, z_in;
   logic [WordWidth-1:0]   w_ff, w_in;
   logic [WordWidth-1:0]   raw_ff, raw_in;
   logic [WordWidth-1:0]   start_ff, start_in;
   logic [WordWidth-1:0]   step_ff, step_in;
   logic [WordWidth-1:0]   diff_ff, diff_in;
   logic [WordWidth-1:0]   n_ff, n_in;
   logic [WordWidth-1:0]   scaled_ff, scaled_in;
   logic [2*WordWidth-1:0] prod_ff, prod_in;
   logic [WordWidth-1:0]   value_ff, value_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [WordWidth-1:0]   step_fix;
   logic [4:0]             shift;
   logic [7:0]             bits_m1;
   logic [WordWidth-1:0]   z_next, w_next;
   logic [WordWidth-1:0]   mul_a, mul_b;
   logic [2*WordWidth-1:0] fix_sum;
   logic [WordWidth-1:0]   div_dividend, div_divisor;
   logic [WordWidth-1:0]   div_quotient, div_remainder;
   logic                   div_busy, div_done;

   mwc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   always_comb begin
      step_fix = (req_range_step == '0) ? WordWidth'(1) : req_range_step;
      bits_m1  = (req_bit_count == 8'd0) ? 8'd0 : req_bit_count - 8'd1;
      shift    = (bits_m1 > 8'(MaxShift)) ? MaxShift : bits_m1[4:0];

      z_next = (32'(MultZ) * 32'(z_ff[15:0])) + 32'(z_ff[31:16]);
      w_next = (32'(MultW) * 32'(w_ff[15:0])) + 32'(w_ff[31:16]);

      mul_a = (cmd.mul_sel == MUL_SCALE) ? n_ff   : step_ff;
      mul_b = (cmd.mul_sel == MUL_SCALE) ? raw_ff : scaled_ff;

      // floor(p / 0xFFFFFFFF) for a product below 2^54.
      fix_sum = prod_ff + {{WordWidth{1'b0}}, prod_ff[2*WordWidth-1:WordWidth]}
                + (2*WordWidth)'(1);

      div_dividend = (cmd.div_sel == DIV_COUNT) ? diff_ff : raw_ff;
      div_divisor  = (cmd.div_sel == DIV_COUNT) ? step_ff : n_ff;

      z_in      = z_ff;
      w_in      = w_ff;
      raw_in    = raw_ff;
      start_in  = start_ff;
      step_in   = step_ff;
      diff_in   = diff_ff;
      n_in      = n_ff;
      scaled_in = scaled_ff;
      prod_in   = prod_ff;
      value_in  = value_ff;

      if (cmd.seed_en) begin
         w_in = (req_seed_first == '0)  ? SeedW : req_seed_first;
         z_in = (req_seed_second == '0) ? SeedZ : req_seed_second;
      end
      if (cmd.load_req) begin
         if (req_cmd == CMD_RANGE) begin
            start_in = req_range_start;
            step_in  = step_fix;
            diff_in  = req_range_stop - req_range_start + step_fix - WordWidth'(1);
         end else begin
            start_in = '0;
            step_in  = WordWidth'(1);
         end
         n_in = WordWidth'(1) << shift;
      end
      if (cmd.count_load) begin
         n_in = div_quotient;
      end
      if (cmd.advance) begin
         z_in   = z_next;
         w_in   = w_next;
         raw_in = {z_next[15:0], 16'h0000} + w_next;
      end
      if (cmd.mul_en) begin
         prod_in = (2*WordWidth)'(mul_a) * (2*WordWidth)'(mul_b);
      end
      if (cmd.scale_fix) begin
         scaled_in = fix_sum[2*WordWidth-1:WordWidth];
      end
      if (cmd.mod_load) begin
         scaled_in = div_remainder;
      end
      if (cmd.out_load) begin
         value_in = start_ff + prod_ff[WordWidth-1:0];
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff    <= raw_in;
      start_ff  <= start_in;
      step_ff   <= step_in;
      diff_ff   <= diff_in;
      n_ff      <= n_in;
      scaled_ff <= scaled_in;
      prod_ff   <= prod_in;
      value_ff  <= value_in;
      if (reset) begin
         z_ff         <= SeedZ;
         w_ff         <= SeedW;
         rsp_valid_ff <= 1'b0;
      end else begin
         z_ff         <= z_in;
         w_ff         <= w_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.div_busy = div_busy;
   assign status.div_done = div_done;
   assign status.big_n    = n_ff > ScaleLimit;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = value_ff;

   // A multiply-with-carry half that starts nonzero can never reach zero.
   `MWC_ASSERT_NEVER(a_halves_nonzero, (z_ff == '0) || (w_ff == '0))
   // A stalled result stays offered and unchanged.
   `MWC_ASSERT(a_rsp_valid_holds, (rsp_valid && rsp_stall) |=> rsp_valid)
   `MWC_ASSERT(a_rsp_value_holds, (rsp_valid && rsp_stall) |=> $stable(rsp_random_value))

endmodule

// ===== rtl/core/mwc_ctrl.sv =====
// Sequencing state machine of the random generator.
`include "assert_macros.svh"
module mwc_ctrl import mwc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_cmd,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               case (req_cmd)
                  CMD_RANGE: state_in = ST_COUNT_DIV;
                  CMD_BITS:  state_in = ST_ADVANCE;
                  CMD_SEED:  cmd.seed_en = 1'b1;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_COUNT_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_COUNT;
            state_in      = ST_COUNT_WAIT;
         end
         ST_COUNT_WAIT: begin
            if (status.div_done) begin
               cmd.count_load = 1'b1;
               state_in       = ST_ADVANCE;
            end
         end
         ST_ADVANCE: begin
            cmd.advance = 1'b1;
            state_in    = status.big_n ? ST_MOD_DIV : ST_SCALE_MUL;
         end
         ST_SCALE_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SCALE;
            state_in    = ST_SCALE_FIX;
         end
         ST_SCALE_FIX: begin
            cmd.scale_fix = 1'b1;
            state_in      = ST_OFFSET_MUL;
         end
         ST_MOD_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_MOD;
            state_in      = ST_MOD_WAIT;
         end
         ST_MOD_WAIT: begin
            if (status.div_done) begin
               cmd.mod_load = 1'b1;
               state_in     = ST_OFFSET_MUL;
            end
         end
         ST_OFFSET_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_OFFSET;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   `MWC_ASSERT(a_div_start_idle, cmd.div_start |-> !status.div_busy)
   `MWC_ASSERT(a_out_load_free, cmd.out_load |-> status.out_free)
   `MWC_ASSERT(a_mod_path_big_n, (state_ff == ST_MOD_WAIT) |-> status.big_n)

endmodule

// ===== rtl/core/mwc_bounded_random_generator.sv =====
// Top level of the multiply-with-carry bounded random generator.
//
// Usage: the request channel (req_valid, req_stall, req_ fields) takes one
// command per transfer. A range draw (req_cmd 0) returns one value in
// start + step * [0, count); a bit-count draw (req_cmd 1) returns one value
// below 2^min(31, bit_count - 1); a reseed (req_cmd 2) loads both halves and
// returns nothing; command 3 is dropped. Each draw produces one transfer on
// the response channel (rsp_valid, rsp_stall, rsp_random_value).
// A bit-count draw with a bound up to 0x3FFFFF scales the raw value on the
// shared multiplier; above it, the shared divider takes the raw value modulo
// the bound. A range draw first divides for the count and then does the same,
// scaling for a count up to 0x3FFFFF and dividing for one above it. The
// divider gives one quotient bit per cycle. req_stall is high from the
// transfer until the result has moved into the output register, and the next
// request is taken in the cycle after. A reseed completes in the cycle of its
// transfer.
// Reset loads the halves with 2 (z) and 1 (w) and empties the output register.
// While the receiver stalls, the result stays in the output register and the
// block may still accept and process the next request, holding its result
// back until the output register is free.
module mwc_bounded_random_generator import mwc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_cmd,
   input  logic [WordWidth-1:0] req_range_start,
   input  logic [WordWidth-1:0] req_range_stop,
   input  logic [WordWidth-1:0] req_range_step,
   input  logic [7:0]           req_bit_count,
   input  logic [WordWidth-1:0] req_seed_first,
   input  logic [WordWidth-1:0] req_seed_second,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WordWidth-1:0] rsp_random_value
);

   // Commands and status between the sequencer and the datapath.
   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   // The controller decodes each accepted request and walks the datapath
   // through count division, generator advance, scaling or modulo division, and offset.
   mwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   // The datapath holds the generator halves, the operands, the shared
   // multiplier and divider, and the response output register.
   mwc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (ctrl_cmd),
      .status           (dp_status),
      .req_cmd          (req_cmd),
      .req_range_start  (req_range_start),
      .req_range_stop   (req_range_stop),
      .req_range_step   (req_range_step),
      .req_bit_count    (req_bit_count),
      .req_seed_first   (req_seed_first),
      .req_seed_second  (req_seed_second),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_random_value (rsp_random_value)
   );

endmodule
